// ----- hw/rtl/enms_pkg.sv -----
`default_nettype none

package enms_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 2048;
  localparam int DEFAULT_MAX_HEIGHT = 2048;

  localparam int MAG_W       = 16;
  localparam int ANGLE_W     = 11;
  localparam int DIM_W       = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [DIM_W-1:0]   FRAME_WIDTH_RESET      = 12'd640;
  localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RESET     = 12'd480;
  localparam logic [ANGLE_W-1:0] HORIZONTAL_UPPER_RESET = 11'd180;
  localparam logic [ANGLE_W-1:0] DIAGONAL_UPPER_RESET   = 11'd540;
  localparam logic [ANGLE_W-1:0] VERTICAL_UPPER_RESET   = 11'd980;
  localparam logic [ANGLE_W-1:0] HORIZONTAL_LOWER_RESET = 11'd1260;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH      = 3'd0,
    REG_FRAME_HEIGHT     = 3'd1,
    REG_HORIZONTAL_UPPER = 3'd2,
    REG_DIAGONAL_UPPER   = 3'd3,
    REG_VERTICAL_UPPER   = 3'd4,
    REG_HORIZONTAL_LOWER = 3'd5
  } cfg_reg_t;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/edge_non_max_suppression.sv -----
`default_nettype none

// channel   handshake                  payload
// cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
// pixel     pixel_valid / pixel_stall  cmd, magnitude, angle
// result    result_valid / result_stall edge_value, frame_last
//
// one item per cycle while pixel_stall is low; a result passes the execute stage, then the result queue
// the first flush of a single-row frame steps two line store positions
// rate set by the single read port of the line store and a 3-entry result queue
// synchronous reset, no line store clearing (entries are written before use)
// pixel_stall rises when the result queue plus the item in flight would overflow, or during a flush retry

module edge_non_max_suppression
  import enms_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  logic                   cmd,
  input  logic [MAG_W-1:0]       magnitude,
  input  logic [ANGLE_W-1:0]     angle,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [MAG_W-1:0]       edge_value,
  output logic                   frame_last
);

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int HW         = $clog2(MAX_HEIGHT + 1);
  localparam int RW         = $clog2(MAX_HEIGHT + 3);
  localparam int PW         = $clog2(MAX_WIDTH + 2);
  localparam int LINE_W     = 2 * MAG_W + ANGLE_W;
  localparam int FIFO_DEPTH = 3;
  localparam int FAW        = $clog2(FIFO_DEPTH);
  localparam int FCW        = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic first_col;
    logic left_ok;
    logic top_ok;
    logic mid_ok;
    logic bot_ok;
    logic out;
    logic last;
    logic restart;
  } step_t;

  // configuration
  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [ANGLE_W-1:0] horizontal_upper;
  logic [ANGLE_W-1:0] diagonal_upper;
  logic [ANGLE_W-1:0] vertical_upper;
  logic [ANGLE_W-1:0] horizontal_lower;
  logic               cfg_restart;

  // position state
  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [PW-1:0] pending_outputs, pending_outputs_next;
  logic          flush_retry, flush_retry_next;

  // issue
  logic [WW-1:0]      w_eff;
  logic [HW-1:0]      h_eff;
  logic [RW-1:0]      h_ext;
  logic               frame_done;
  logic               space_ok;
  logic               take;
  logic               issue;
  logic               restart;
  logic [MAG_W-1:0]   issue_mag;
  logic [ANGLE_W-1:0] issue_angle;
  logic [RW-1:0]      pos_row;
  logic [CW-1:0]      col_raw;
  logic [CW-1:0]      pos_col;
  logic [PW-1:0]      pend_base;
  step_t              step;

  // execute stage
  logic               s1_valid;
  step_t              s1_step;
  logic [CW-1:0]      s1_addr;
  logic [MAG_W-1:0]   s1_mag;
  logic [ANGLE_W-1:0] s1_angle;
  logic               fwd_hit;
  logic [LINE_W-1:0]  fwd_data;
  logic [LINE_W-1:0]  ram_q;
  logic [LINE_W-1:0]  line_rd;
  logic [LINE_W-1:0]  line_wr;
  logic [MAG_W-1:0]   new_col [3];
  logic [ANGLE_W-1:0] new_angle;
  logic [MAG_W-1:0]   centre_col [3];
  logic [MAG_W-1:0]   left_col [3];
  logic [MAG_W-1:0]   right_col [3];
  logic [MAG_W-1:0]   mid_slot [3];
  logic [ANGLE_W-1:0] centre_angle;
  logic [ANGLE_W-1:0] mid_angle;
  logic [MAG_W-1:0]   nb_a;
  logic [MAG_W-1:0]   nb_b;
  logic [MAG_W-1:0]   result_mag;

  logic [MAG_W-1:0]   window_mag [3][3];
  logic [ANGLE_W-1:0] window_angle [3];

  // result queue
  logic [MAG_W-1:0] fifo_mag [FIFO_DEPTH];
  logic             fifo_last [FIFO_DEPTH];
  logic [FAW-1:0]   fifo_rd;
  logic [FAW-1:0]   fifo_wr;
  logic [FCW-1:0]   fifo_count;
  logic             push;
  logic             pop;

  assign cfg_ready   = 1'b1;
  assign cfg_restart = cfg_valid && cfg_ready &&
                       (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= FRAME_WIDTH_RESET;
      frame_height     <= FRAME_HEIGHT_RESET;
      horizontal_upper <= HORIZONTAL_UPPER_RESET;
      diagonal_upper   <= DIAGONAL_UPPER_RESET;
      vertical_upper   <= VERTICAL_UPPER_RESET;
      horizontal_lower <= HORIZONTAL_LOWER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:      frame_width      <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:     frame_height     <= cfg_data[DIM_W-1:0];
        REG_HORIZONTAL_UPPER: horizontal_upper <= cfg_data[ANGLE_W-1:0];
        REG_DIAGONAL_UPPER:   diagonal_upper   <= cfg_data[ANGLE_W-1:0];
        REG_VERTICAL_UPPER:   vertical_upper   <= cfg_data[ANGLE_W-1:0];
        REG_HORIZONTAL_LOWER: horizontal_lower <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height);
    end
    h_ext      = RW'(h_eff);
    frame_done = row_count >= h_ext;
    space_ok   = ({1'b0, fifo_count} + (FCW + 1)'(s1_valid && s1_step.out)) <= (FCW + 1)'(2);

    pixel_stall = flush_retry || !space_ok;
    take        = pixel_valid && !pixel_stall;
    restart     = take && cmd == CMD_PIXEL && frame_done;

    issue       = 1'b0;
    issue_mag   = '0;
    issue_angle = '0;
    if (flush_retry) begin
      issue = space_ok;
    end else if (take) begin
      if (cmd == CMD_PIXEL) begin
        issue       = 1'b1;
        issue_mag   = magnitude;
        issue_angle = angle;
      end else begin
        issue = frame_done && pending_outputs != '0;
      end
    end

    pos_row = restart ? '0 : row_count;
    col_raw = restart ? '0 : column_count;
    pos_col = (WW'(col_raw) >= w_eff) ? CW'(w_eff - WW'(1)) : col_raw;

    step.first_col = pos_col == '0;
    step.top_ok    = pos_row >= RW'(2) && pos_row <= h_ext + RW'(1);
    step.mid_ok    = pos_row >= RW'(1) && pos_row <= h_ext;
    step.bot_ok    = pos_row < h_ext;
    step.out       = step.first_col ? step.top_ok : step.mid_ok;
    step.left_ok   = step.first_col ? (w_eff >= WW'(2)) : (WW'(pos_col) >= WW'(2));
    step.last      = step.first_col && pos_row == h_ext + RW'(1);
    step.restart   = restart;

    pend_base            = restart ? '0 : pending_outputs;
    column_count_next    = column_count;
    row_count_next       = row_count;
    pending_outputs_next = pending_outputs;
    flush_retry_next     = flush_retry;
    if (issue) begin
      if (WW'(pos_col) + WW'(1) >= w_eff) begin
        column_count_next = '0;
        row_count_next    = pos_row + RW'(1);
      end else begin
        column_count_next = pos_col + CW'(1);
        row_count_next    = pos_row;
      end
      if (flush_retry) begin
        flush_retry_next = 1'b0;
        if (step.out) begin
          pending_outputs_next = pend_base - PW'(1);
        end
      end else if (cmd == CMD_PIXEL) begin
        pending_outputs_next = pend_base + PW'(1) - PW'(step.out);
      end else if (step.out) begin
        pending_outputs_next = pend_base - PW'(1);
      end else begin
        // single-row drain: step over the position that has no result
        flush_retry_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      column_count    <= '0;
      row_count       <= '0;
      pending_outputs <= '0;
      flush_retry     <= 1'b0;
    end else begin
      column_count    <= column_count_next;
      row_count       <= row_count_next;
      pending_outputs <= pending_outputs_next;
      flush_retry     <= flush_retry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= issue;
      fwd_hit  <= s1_valid && s1_addr == pos_col;
    end
    fwd_data <= line_wr;
    if (issue) begin
      s1_step  <= step;
      s1_addr  <= pos_col;
      s1_mag   <= issue_mag;
      s1_angle <= issue_angle;
    end
  end

  enms_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (s1_valid),
    .wr_addr(s1_addr),
    .wr_data(line_wr),
    .rd_en  (issue),
    .rd_addr(pos_col),
    .rd_data(ram_q)
  );

  always_comb begin
    line_rd    = fwd_hit ? fwd_data : ram_q;
    new_col[0] = s1_step.top_ok ? line_rd[LINE_W-1 -: MAG_W] : '0;
    new_col[1] = s1_step.mid_ok ? line_rd[ANGLE_W +: MAG_W] : '0;
    new_col[2] = s1_step.bot_ok ? s1_mag : '0;
    new_angle  = s1_step.mid_ok ? line_rd[ANGLE_W-1:0] : '0;
    line_wr    = {new_col[1], new_col[2], s1_step.bot_ok ? s1_angle : '0};

    for (int j = 0; j < 3; j++) begin
      centre_col[j] = s1_step.restart ? '0 : window_mag[2][j];
      mid_slot[j]   = s1_step.restart ? '0 : window_mag[1][j];
      left_col[j]   = s1_step.left_ok ? mid_slot[j] : '0;
      right_col[j]  = s1_step.first_col ? '0 : new_col[j];
    end
    centre_angle = s1_step.restart ? '0 : window_angle[2];
    mid_angle    = s1_step.restart ? '0 : window_angle[1];

    if (centre_angle <= horizontal_upper || centre_angle >= horizontal_lower) begin
      nb_a = left_col[1];
      nb_b = right_col[1];
    end else if (centre_angle < diagonal_upper) begin
      nb_a = left_col[0];
      nb_b = right_col[2];
    end else if (centre_angle < vertical_upper) begin
      nb_a = centre_col[0];
      nb_b = centre_col[2];
    end else begin
      nb_a = right_col[0];
      nb_b = left_col[2];
    end
    result_mag = (centre_col[1] > nb_a && centre_col[1] > nb_b) ? centre_col[1] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          window_mag[k][j] <= '0;
        end
        window_angle[k] <= '0;
      end
    end else if (s1_valid) begin
      for (int j = 0; j < 3; j++) begin
        window_mag[0][j] <= mid_slot[j];
        window_mag[1][j] <= centre_col[j];
        window_mag[2][j] <= new_col[j];
      end
      window_angle[0] <= mid_angle;
      window_angle[1] <= centre_angle;
      window_angle[2] <= new_angle;
    end
  end

  assign push         = s1_valid && s1_step.out;
  assign result_valid = fifo_count != '0;
  assign pop          = result_valid && !result_stall;
  assign edge_value   = fifo_mag[fifo_rd];
  assign frame_last   = fifo_last[fifo_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_rd    <= '0;
      fifo_wr    <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        fifo_wr <= (fifo_wr == FAW'(FIFO_DEPTH - 1)) ? '0 : fifo_wr + FAW'(1);
      end
      if (pop) begin
        fifo_rd <= (fifo_rd == FAW'(FIFO_DEPTH - 1)) ? '0 : fifo_rd + FAW'(1);
      end
      fifo_count <= fifo_count + FCW'(push) - FCW'(pop);
    end
    if (push) begin
      fifo_mag[fifo_wr]  <= result_mag;
      fifo_last[fifo_wr] <= s1_step.last;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/enms_ram.sv -----
`default_nettype none

module enms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import enms_pkg::*;

  localparam int unsigned MAX_W          = DEFAULT_MAX_WIDTH;
  localparam int unsigned MAX_H          = DEFAULT_MAX_HEIGHT;
  localparam int unsigned RANDOM_ITEMS   = 1880;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_PRINTS     = 100;

  localparam cfg_reg_t ANGLE_REGS [4] = '{REG_HORIZONTAL_UPPER, REG_DIAGONAL_UPPER,
                                          REG_VERTICAL_UPPER, REG_HORIZONTAL_LOWER};

  // two 3x3 frames: every boundary of the default quantizer, then ties and wide angles
  localparam logic [MAG_W-1:0] DIR_MAGS [18] = '{
    16'd10, 16'd20, 16'd30, 16'd40, 16'd65535, 16'd40, 16'd30, 16'd20, 16'd10,
    16'd65535, 16'd0, 16'd7, 16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd1};
  localparam logic [ANGLE_W-1:0] DIR_ANGLES [18] = '{
    11'd0, 11'd180, 11'd181, 11'd539, 11'd540, 11'd979, 11'd980, 11'd1259, 11'd1260,
    11'd1440, 11'd2047, 11'd1024, 11'd0, 11'd2047, 11'd512, 11'd256, 11'd128, 11'd64};

  typedef struct packed {
    logic               cmd_bit;
    logic [MAG_W-1:0]   mag;
    logic [ANGLE_W-1:0] ang;
  } pixel_item_t;

  typedef struct packed {
    logic [MAG_W-1:0] edge_value;
    logic             frame_last;
  } edge_result_t;

  typedef struct packed {
    cfg_reg_t                idx;
    logic [CFG_DATA_W-1:0]   val;
  } reg_write_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   pixel_valid  = 1'b0;
  logic                   pixel_stall;
  logic                   cmd          = CMD_PIXEL;
  logic [MAG_W-1:0]       magnitude    = '0;
  logic [ANGLE_W-1:0]     angle        = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [MAG_W-1:0]       edge_value;
  logic                   frame_last;

  edge_non_max_suppression dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .cmd          (cmd),
    .magnitude    (magnitude),
    .angle        (angle),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .edge_value   (edge_value),
    .frame_last   (frame_last)
  );

  // suppression model state
  logic [MAG_W-1:0]   upper_mags    [MAX_W];
  logic [MAG_W-1:0]   middle_mags   [MAX_W];
  logic [ANGLE_W-1:0] middle_angles [MAX_W];
  logic [MAG_W-1:0]   win_mags [3][3] = '{default: '0};  // [column slot][row]
  logic [ANGLE_W-1:0] win_angles [3]  = '{default: '0};
  logic [MAG_W-1:0]   nbr [3][3];                         // [row][left, centre, right]
  int unsigned        col_pos      = 0;
  int unsigned        row_pos      = 0;
  int unsigned        owed_results = 0;

  logic [DIM_W-1:0]   width_reg  = FRAME_WIDTH_RESET;
  logic [DIM_W-1:0]   height_reg = FRAME_HEIGHT_RESET;
  logic [ANGLE_W-1:0] horiz_up   = HORIZONTAL_UPPER_RESET;
  logic [ANGLE_W-1:0] diag_up    = DIAGONAL_UPPER_RESET;
  logic [ANGLE_W-1:0] vert_up    = VERTICAL_UPPER_RESET;
  logic [ANGLE_W-1:0] horiz_lo   = HORIZONTAL_LOWER_RESET;

  pixel_item_t  pending_pixels [$];
  edge_result_t expected_edges [$];
  reg_write_t   reg_q [$];

  int unsigned items_outstanding = 0;
  int unsigned random_items      = 0;
  int unsigned fail_count        = 0;
  int unsigned gap_left          = 0;
  int unsigned stall_left        = 0;
  int unsigned idle_cycles       = 0;
  bit          pixel_calm        = 1'b0;
  bit          result_calm       = 1'b0;

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void restart_frame();
    for (int s = 0; s < 3; s++) begin
      win_angles[s] = '0;
      for (int r = 0; r < 3; r++) win_mags[s][r] = '0;
    end
    col_pos      = 0;
    row_pos      = 0;
    owed_results = 0;
  endfunction

  function automatic void gather_window(input int centre, input bit left_ok, input bit right_ok);
    for (int r = 0; r < 3; r++) begin
      nbr[r][0] = '0;
      nbr[r][2] = '0;
      if (left_ok) nbr[r][0] = win_mags[centre - 1][r];
      nbr[r][1] = win_mags[centre][r];
      if (right_ok) nbr[r][2] = win_mags[centre + 1][r];
    end
  endfunction

  function automatic logic [MAG_W-1:0] local_max(input logic [ANGLE_W-1:0] a);
    logic [MAG_W-1:0] n1, n2, g;
    g = nbr[1][1];
    if (a <= horiz_up || a >= horiz_lo) begin
      n1 = nbr[1][0];
      n2 = nbr[1][2];
    end else if (a < diag_up) begin
      n1 = nbr[0][0];
      n2 = nbr[2][2];
    end else if (a < vert_up) begin
      n1 = nbr[0][1];
      n2 = nbr[2][1];
    end else begin
      n1 = nbr[0][2];
      n2 = nbr[2][0];
    end
    return (g > n1 && g > n2) ? g : '0;
  endfunction

  // one raster position, real pixel or drain step
  function automatic void step_position(input logic [MAG_W-1:0] mag,
                                        input logic [ANGLE_W-1:0] ang,
                                        output bit hit, output edge_result_t res);
    int unsigned        w, h, r, c;
    logic [ANGLE_W-1:0] centre_ang, a;
    logic [MAG_W-1:0]   top, mid, bot;
    longint unsigned    pos, total;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);
    r = row_pos;
    c = col_pos;
    hit = 1'b0;
    res = '0;
    centre_ang = '0;
    if (c >= w) c = w - 1;
    if (c == 0) begin
      gather_window(2, w >= 2, 1'b0);
      centre_ang = win_angles[2];
    end
    top = (r >= 2 && r - 2 < h) ? upper_mags[c] : '0;
    mid = (r >= 1 && r - 1 < h) ? middle_mags[c] : '0;
    a   = (r >= 1 && r - 1 < h) ? middle_angles[c] : '0;
    bot = (r < h) ? mag : '0;
    upper_mags[c]    = mid;
    middle_mags[c]   = bot;
    middle_angles[c] = (r < h) ? ang : '0;
    for (int s = 0; s < 2; s++) begin
      win_angles[s] = win_angles[s + 1];
      for (int k = 0; k < 3; k++) win_mags[s][k] = win_mags[s + 1][k];
    end
    win_mags[2][0] = top;
    win_mags[2][1] = mid;
    win_mags[2][2] = bot;
    win_angles[2]  = a;
    if (c != 0) begin
      gather_window(1, c >= 2, 1'b1);
      centre_ang = win_angles[1];
    end
    pos   = 64'(r) * 64'(w) + 64'(c);
    total = 64'(w) * 64'(h);
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    if (pos >= 64'(w) + 1 && pos - 64'(w) - 1 < total) begin
      hit = 1'b1;
      res.edge_value = local_max(centre_ang);
      res.frame_last = (pos - 64'(w) - 1 == total - 1);
    end
  endfunction

  function automatic void predict_item(input logic cmd_bit, input logic [MAG_W-1:0] mag,
                                       input logic [ANGLE_W-1:0] ang);
    bit           hit;
    edge_result_t res;
    hit = 1'b0;
    if (cmd_bit == CMD_PIXEL) begin
      if (row_pos >= eff_dim(height_reg, MAX_H)) restart_frame();
      owed_results++;
      step_position(mag, ang, hit, res);
    end else if (row_pos >= eff_dim(height_reg, MAX_H) && owed_results != 0) begin
      // a single-row frame may need a second step before a result shows
      step_position('0, '0, hit, res);
      if (!hit) step_position('0, '0, hit, res);
    end
    if (hit) begin
      owed_results--;
      expected_edges.push_back(res);
    end
  endfunction

  function automatic void apply_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = val;
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = val;
        restart_frame();
      end
      REG_HORIZONTAL_UPPER: horiz_up = val[ANGLE_W-1:0];
      REG_DIAGONAL_UPPER:   diag_up  = val[ANGLE_W-1:0];
      REG_VERTICAL_UPPER:   vert_up  = val[ANGLE_W-1:0];
      REG_HORIZONTAL_LOWER: horiz_lo = val[ANGLE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap(input bit calm_mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm_mode || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [MAG_W-1:0] rand_mag();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return MAG_W'($urandom_range(0, 3));
    if (roll < 28) return $urandom_range(0, 1) ? '1 : '0;
    return MAG_W'($urandom());
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_angle();
    int unsigned roll;
    int          base;
    roll = $urandom_range(0, 99);
    base = 0;
    if (roll < 10) return ANGLE_W'($urandom_range(1441, 2047));
    if (roll < 35) begin
      case ($urandom_range(0, 3))
        0: base = horiz_up;
        1: base = diag_up;
        2: base = vert_up;
        default: base = horiz_lo;
      endcase
      base = base + int'($urandom_range(0, 2)) - 1;
      if (base < 0) base = 0;
      if (base > 2047) base = 2047;
      return ANGLE_W'(base);
    end
    return ANGLE_W'($urandom_range(0, 1440));
  endfunction

  function automatic void queue_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    reg_write_t wr;
    wr.idx = idx;
    wr.val = val;
    reg_q.push_back(wr);
  endfunction

  function automatic void push_item(input logic cmd_bit, input logic [MAG_W-1:0] mag,
                                    input logic [ANGLE_W-1:0] ang);
    pixel_item_t it;
    it.cmd_bit = cmd_bit;
    it.mag     = mag;
    it.ang     = ang;
    pending_pixels.push_back(it);
    items_outstanding++;
  endfunction

  // mostly ordered boundaries, sometimes extremes in any order
  function automatic void queue_angle_regs();
    int unsigned th [4];
    if ($urandom_range(0, 4) < 3) begin
      th[0] = $urandom_range(0, 360);
      th[1] = $urandom_range(th[0], 720);
      th[2] = $urandom_range(th[1], 1080);
      th[3] = $urandom_range(th[2], 1440);
    end else begin
      foreach (th[k]) begin
        case ($urandom_range(0, 3))
          0: th[k] = 0;
          1: th[k] = 1440;
          2: th[k] = 2047;
          default: th[k] = $urandom_range(0, 2047);
        endcase
      end
    end
    foreach (th[k]) begin
      if ($urandom_range(0, 1) != 0)
        queue_reg(ANGLE_REGS[k], {1'($urandom_range(0, 1)), ANGLE_W'(th[k])});
    end
  endfunction

  // one frame in raster order with stray flushes, optionally drained by flushes
  function automatic void queue_frame(input int unsigned w, input int unsigned h,
                                      input bit drain);
    int unsigned npix, owed, nflush;
    npix = w * h;
    for (int unsigned k = 0; k < npix; k++) begin
      if (k != 0 && $urandom_range(0, 24) == 0) push_item(CMD_FLUSH, rand_mag(), rand_angle());
      push_item(CMD_PIXEL, rand_mag(), rand_angle());
    end
    random_items += npix;
    if (drain) begin
      owed   = (npix < w + 1) ? npix : w + 1;
      nflush = owed + $urandom_range(0, 2);
      for (int unsigned k = 0; k < nflush; k++) push_item(CMD_FLUSH, rand_mag(), rand_angle());
      random_items += owed;
    end
  endfunction

  task automatic send_regs();
    reg_write_t wr;
    while (reg_q.size() != 0) begin
      wr = reg_q.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= wr.idx;
      cfg_data  <= wr.val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(wr.idx, wr.val);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (items_outstanding != 0 || expected_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("%0t mismatch: %s", $time, msg);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : pixel_driver
    pixel_item_t nxt;
    if (rst) begin
      pixel_valid <= 1'b0;
      gap_left = 0;
    end else if (!pixel_valid || !pixel_stall) begin
      if (pixel_valid) begin
        predict_item(cmd, magnitude, angle);
        items_outstanding--;
      end
      if (gap_left != 0 || pending_pixels.size() == 0) begin
        if (gap_left != 0) gap_left--;
        pixel_valid <= 1'b0;
      end else begin
        nxt = pending_pixels.pop_front();
        pixel_valid <= 1'b1;
        cmd         <= nxt.cmd_bit;
        magnitude   <= nxt.mag;
        angle       <= nxt.ang;
        gap_left = pick_gap(pixel_calm);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    edge_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_edges.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: edge_value %0d frame_last %0b",
                                    edge_value, frame_last));
        end else begin
          want = expected_edges.pop_front();
          if (edge_value !== want.edge_value)
            report_mismatch($sformatf("edge_value %0d, want %0d", edge_value, want.edge_value));
          if (frame_last !== want.frame_last)
            report_mismatch($sformatf("frame_last %0b, want %0b", frame_last, want.frame_last));
        end
      end
      if (stall_left == 0) stall_left = pick_gap(result_calm);
      if (stall_left != 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned w_val, h_val, nframes, roll;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 3x3 frames with every boundary, partial drain, frame overrun
    queue_reg(REG_FRAME_WIDTH, 12'd3);
    queue_reg(REG_FRAME_HEIGHT, 12'd3);
    queue_reg(REG_HORIZONTAL_UPPER, 12'd180);
    queue_reg(REG_DIAGONAL_UPPER, 12'd540);
    queue_reg(REG_VERTICAL_UPPER, 12'd980);
    queue_reg(REG_HORIZONTAL_LOWER, 12'd1260);
    send_regs();
    push_item(CMD_FLUSH, '0, '0);
    for (int k = 0; k < 9; k++) push_item(CMD_PIXEL, DIR_MAGS[k], DIR_ANGLES[k]);
    repeat (2) push_item(CMD_FLUSH, '1, '1);
    for (int k = 9; k < 18; k++) push_item(CMD_PIXEL, DIR_MAGS[k], DIR_ANGLES[k]);
    repeat (5) push_item(CMD_FLUSH, '0, '0);
    settle();

    // zero width and height act as 1x1 frames
    queue_reg(REG_FRAME_WIDTH, 12'd0);
    queue_reg(REG_FRAME_HEIGHT, 12'd0);
    send_regs();
    queue_frame(1, 1, 1'b1);
    queue_frame(1, 1, 1'b0);
    queue_frame(1, 1, 1'b1);
    settle();

    // widest row, single-row frame, everything horizontal
    pixel_calm  = 1'b0;
    result_calm = 1'b1;
    queue_reg(REG_FRAME_WIDTH, 12'hFFF);
    queue_reg(REG_FRAME_HEIGHT, 12'd1);
    queue_reg(REG_HORIZONTAL_UPPER, 12'd0);
    queue_reg(REG_DIAGONAL_UPPER, 12'd1440);
    queue_reg(REG_VERTICAL_UPPER, 12'hFFF);
    queue_reg(REG_HORIZONTAL_LOWER, 12'h800);
    send_regs();
    queue_frame(MAX_W, 1, 1'b1);
    settle();

    // tallest frame, left unfinished
    result_calm = 1'b0;
    queue_reg(REG_FRAME_WIDTH, 12'd2);
    queue_reg(REG_FRAME_HEIGHT, 12'hFFF);
    queue_angle_regs();
    send_regs();
    repeat (40) push_item(CMD_PIXEL, rand_mag(), rand_angle());
    push_item(CMD_FLUSH, '0, '0);
    settle();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      roll  = $urandom_range(0, 99);
      w_val = (roll < 5) ? 0 : (roll < 75) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      roll  = $urandom_range(0, 99);
      h_val = (roll < 8) ? 0 : (roll < 70) ? $urandom_range(1, 4) : $urandom_range(5, 8);
      queue_reg(REG_FRAME_WIDTH, DIM_W'(w_val));
      queue_reg(REG_FRAME_HEIGHT, DIM_W'(h_val));
      queue_angle_regs();
      send_regs();
      pixel_calm  = ($urandom_range(0, 3) == 0);
      result_calm = ($urandom_range(0, 3) == 0);
      nframes = $urandom_range(1, 3);
      repeat (nframes)
        queue_frame(eff_dim(DIM_W'(w_val), MAX_W), eff_dim(DIM_W'(h_val), MAX_H),
                    $urandom_range(0, 9) != 0);
      settle();
    end

    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
